// ===== hdl/compacting_key_value_table_macros.svh =====
// assertion macros shared by the key and value table
`ifndef COMPACTING_KEY_VALUE_TABLE_MACROS_SVH
`define COMPACTING_KEY_VALUE_TABLE_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define CKVT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while reset is held
`define CKVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ckvt_pkg.sv =====
// shared types and constants of the key and value table
`timescale 1ns / 1ps

package ckvt_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int KEY_BYTES_DEF = 8;
    localparam int FUNC_W        = 2;
    localparam int KEY_TEXT_W    = 64;
    localparam int VALUE_W       = 32;
    localparam int TOTAL_W       = 5;

    // operation codes carried on a request beat
    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUT    = 2'd0,
        FUNC_GET    = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan;
        logic shift_start;
        logic shift;
        logic commit;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic  hit_now;
        logic  drained;
        logic  out_free;
        t_func func;
    } t_dp_status;

endpackage

// ===== hdl/compacting_key_value_table.sv =====
// top level of the compacting key and value table
// flow: a request is latched, the entries are scanned in order until a hit or the end,
//   a remove hit then moves the later entries down, and the result is written;
//   a no-op request (code 3) skips the scan
// requests: a new request beat is taken only in the idle state, once the result of
//   the last one is written; scan and compaction handle one entry a cycle
// reset: synchronous active low, empties the table; stores are not cleared
`timescale 1ns / 1ps

`include "compacting_key_value_table_macros.svh"

module compacting_key_value_table #(
    parameter int CAPACITY  = ckvt_pkg::CAPACITY_DEF,
    parameter int KEY_BYTES = ckvt_pkg::KEY_BYTES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [ckvt_pkg::FUNC_W-1:0]          i_func,
    input  logic [ckvt_pkg::KEY_TEXT_W-1:0]      i_key_text,
    input  logic signed [ckvt_pkg::VALUE_W-1:0]  i_new_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_found,
    output logic signed [ckvt_pkg::VALUE_W-1:0]  o_read_value,
    output logic                                 o_table_full,
    output logic [ckvt_pkg::TOTAL_W-1:0]         o_entry_total
);
    import ckvt_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // controller
    ckvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_status   (dp_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (dp_cmd)
    );

    // datapath
    ckvt_datapath #(
        .CAPACITY  (CAPACITY),
        .KEY_BYTES (KEY_BYTES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_func        (i_func),
        .i_key_text    (i_key_text),
        .i_new_value   (i_new_value),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_found       (o_found),
        .o_read_value  (o_read_value),
        .o_table_full  (o_table_full),
        .o_entry_total (o_entry_total)
    );

    // checks
    `CKVT_ASSERT_IMPLY(a_full_excl, i_clk, i_rst_n, o_out_valid && o_table_full, !o_found && (o_read_value == '0), "dropped put shows a hit or a value")
    `CKVT_ASSERT_IMPLY(a_commit_free, i_clk, i_rst_n, dp_cmd.commit, dp_status.out_free, "result written over an untaken beat")
    `CKVT_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "request taken while previous one in flight")

endmodule

// ===== hdl/ckvt_ctrl.sv =====
// controller state machine of the key and value table
`timescale 1ns / 1ps

module ckvt_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [ckvt_pkg::FUNC_W-1:0]   i_func,
    input  ckvt_pkg::t_dp_status          i_status,
    output logic                          o_in_stall,
    output ckvt_pkg::t_dp_cmd             o_cmd
);
    import ckvt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // only the idle state takes a request beat
    assign o_in_stall = (r_state != ST_IDLE);

    // next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_func == FUNC_NONE) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.hit_now) begin
                    if (i_status.func == FUNC_REMOVE) begin
                        o_cmd.shift_start = 1'b1;
                        n_state = ST_SHIFT;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end else if (i_status.drained) begin
                    n_state = ST_FINISH;
                end
            end
            ST_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_status.drained) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

endmodule

// ===== hdl/ckvt_datapath.sv =====
// entry stores, scan pipe and result register of the key and value table
`timescale 1ns / 1ps

module ckvt_datapath #(
    parameter int CAPACITY  = ckvt_pkg::CAPACITY_DEF,
    parameter int KEY_BYTES = ckvt_pkg::KEY_BYTES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ckvt_pkg::t_dp_cmd                    i_cmd,
    output ckvt_pkg::t_dp_status                 o_status,
    input  logic [ckvt_pkg::FUNC_W-1:0]          i_func,
    input  logic [ckvt_pkg::KEY_TEXT_W-1:0]      i_key_text,
    input  logic signed [ckvt_pkg::VALUE_W-1:0]  i_new_value,
    input  logic                                 i_out_stall,
    output logic                                 o_out_valid,
    output logic                                 o_found,
    output logic signed [ckvt_pkg::VALUE_W-1:0]  o_read_value,
    output logic                                 o_table_full,
    output logic [ckvt_pkg::TOTAL_W-1:0]         o_entry_total
);
    import ckvt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int KEY_W = 8 * KEY_BYTES;

    // entry stores, one write and one read port
    logic [KEY_W-1:0]   key_mem [CAPACITY];
    logic [VALUE_W-1:0] val_mem [CAPACITY];

    // latched request
    t_func              r_func;
    logic [KEY_W-1:0]   r_key;
    logic [VALUE_W-1:0] r_val;

    // scan pipe
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_ptr;
    logic               r_cmp_vld;
    logic [IDX_W-1:0]   r_cmp_idx;
    logic [KEY_W-1:0]   r_rd_key;
    logic [VALUE_W-1:0] r_rd_val;

    // lookup outcome
    logic               r_hit;
    logic [IDX_W-1:0]   r_slot;
    logic [VALUE_W-1:0] r_hit_val;

    // result register
    logic               r_o_valid;
    logic               r_o_found;
    logic [VALUE_W-1:0] r_o_read_value;
    logic               r_o_full;
    logic [TOTAL_W-1:0] r_o_total;

    logic [KEY_W-1:0]   norm_key;
    logic               key_alive;
    logic               issue;
    logic               hit_now;
    logic               is_full;
    logic               wr_key_en;
    logic               wr_val_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [KEY_W-1:0]   wr_key;
    logic [VALUE_W-1:0] wr_val;
    logic [CNT_W-1:0]   n_count;

    // key normalisation: drop bytes from the first zero byte onwards
    always_comb begin
        key_alive = 1'b1;
        norm_key  = '0;
        for (int b = 0; b < KEY_BYTES; b++) begin
            if (i_key_text[8*b +: 8] == 8'h00) begin
                key_alive = 1'b0;
            end
            if (key_alive) begin
                norm_key[8*b +: 8] = i_key_text[8*b +: 8];
            end
        end
    end

    // request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= t_func'(i_func);
            r_key  <= norm_key;
            r_val  <= i_new_value;
        end
    end

    assign issue   = (i_cmd.scan || i_cmd.shift) && (r_ptr < r_count);
    assign hit_now = r_cmp_vld && (r_rd_key == r_key);
    assign is_full = (r_count == CNT_W'(CAPACITY));

    // read pointer and compare tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else if (i_cmd.load) begin
            r_ptr     <= '0;
            r_cmp_vld <= 1'b0;
        end else if (i_cmd.shift_start) begin
            r_ptr     <= CNT_W'(r_cmp_idx) + CNT_W'(1);
            r_cmp_vld <= 1'b0;
        end else if (issue) begin
            r_ptr     <= r_ptr + CNT_W'(1);
            r_cmp_idx <= r_ptr[IDX_W-1:0];
            r_cmp_vld <= 1'b1;
        end else if (i_cmd.scan || i_cmd.shift) begin
            r_cmp_vld <= 1'b0;
        end
    end

    // store read port
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_key <= key_mem[r_ptr[IDX_W-1:0]];
            r_rd_val <= val_mem[r_ptr[IDX_W-1:0]];
        end
    end

    // lookup outcome capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_cmd.load) begin
            r_hit <= 1'b0;
        end else if (i_cmd.scan && hit_now) begin
            r_hit     <= 1'b1;
            r_slot    <= r_cmp_idx;
            r_hit_val <= r_rd_val;
        end
    end

    // write port select: compaction move, value update or append
    always_comb begin
        wr_key_en = 1'b0;
        wr_val_en = 1'b0;
        wr_addr   = r_slot;
        wr_key    = r_key;
        wr_val    = r_val;
        n_count   = r_count;
        if (i_cmd.shift && r_cmp_vld) begin
            wr_key_en = 1'b1;
            wr_val_en = 1'b1;
            wr_addr   = r_cmp_idx - IDX_W'(1);
            wr_key    = r_rd_key;
            wr_val    = r_rd_val;
        end else if (i_cmd.commit) begin
            priority if (r_func == FUNC_PUT && r_hit) begin
                wr_val_en = 1'b1;
            end else if (r_func == FUNC_PUT && !is_full) begin
                wr_key_en = 1'b1;
                wr_val_en = 1'b1;
                wr_addr   = r_count[IDX_W-1:0];
                n_count   = r_count + CNT_W'(1);
            end else if (r_func == FUNC_REMOVE && r_hit) begin
                n_count   = r_count - CNT_W'(1);
            end else begin
                n_count   = r_count;
            end
        end
    end

    // store write port
    always_ff @(posedge i_clk) begin
        if (wr_key_en) begin
            key_mem[wr_addr] <= wr_key;
        end
        if (wr_val_en) begin
            val_mem[wr_addr] <= wr_val;
        end
    end

    // live entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // result register, free when empty or being taken
    assign o_status.out_free = !r_o_valid || !i_out_stall;
    assign o_status.hit_now  = hit_now;
    assign o_status.drained  = !r_cmp_vld && (r_ptr >= r_count);
    assign o_status.func     = r_func;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_found      <= r_hit;
            r_o_read_value <= (r_func == FUNC_GET && r_hit) ? r_hit_val : '0;
            r_o_full       <= (r_func == FUNC_PUT) && !r_hit && is_full;
            r_o_total      <= TOTAL_W'(n_count);
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_found       = r_o_found;
    assign o_read_value  = r_o_read_value;
    assign o_table_full  = r_o_full;
    assign o_entry_total = r_o_total;

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench of the compacting key and value table
`timescale 1ns / 1ps

module testbench;
    import ckvt_pkg::*;

    localparam int TABLE_SLOTS = CAPACITY_DEF;
    localparam int POOL_SIZE   = 24;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_GAP   = 60;
    localparam int PRINT_CAP   = 100;

    // one request beat and one result beat
    typedef struct packed {
        t_func                      func;
        logic [KEY_TEXT_W-1:0]      key_text;
        logic signed [VALUE_W-1:0]  new_value;
    } t_table_op;

    typedef struct packed {
        logic                       found;
        logic signed [VALUE_W-1:0]  read_value;
        logic                       table_full;
        logic [TOTAL_W-1:0]         entry_total;
    } t_table_reply;

    logic                       i_clk;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_stall;
    logic [FUNC_W-1:0]          i_func      = '0;
    logic [KEY_TEXT_W-1:0]      i_key_text  = '0;
    logic signed [VALUE_W-1:0]  i_new_value = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic                       o_found;
    logic signed [VALUE_W-1:0]  o_read_value;
    logic                       o_table_full;
    logic [TOTAL_W-1:0]         o_entry_total;

    compacting_key_value_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_key_text    (i_key_text),
        .i_new_value   (i_new_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_found       (o_found),
        .o_read_value  (o_read_value),
        .o_table_full  (o_table_full),
        .o_entry_total (o_entry_total)
    );

    // clock, 4 ns period
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // shadow copy of the table
    logic [KEY_TEXT_W-1:0]      shadow_keys [TABLE_SLOTS];
    logic signed [VALUE_W-1:0]  shadow_vals [TABLE_SLOTS];
    int                         shadow_count = 0;

    t_table_op      pending_ops[$];
    t_table_reply   predicted_replies[$];
    int             ops_queued   = 0;
    int             ops_accepted = 0;
    int             fail_count   = 0;
    int             send_idle_pct = 7;
    int             recv_idle_pct = 68;
    int             holds_asked  = 0;
    int             holds_served = 0;
    int             hold_left    = 0;
    logic           in_taken     = 1'b0;

    logic [KEY_TEXT_W-1:0]  key_pool [POOL_SIZE];
    int                     key_pool_len [POOL_SIZE];

    t_table_op      next_op;
    t_table_op      seen_op;
    t_table_reply   want;

    // clear bytes from the first zero byte upwards
    function automatic logic [KEY_TEXT_W-1:0] trim_key(input logic [KEY_TEXT_W-1:0] raw);
        logic [KEY_TEXT_W-1:0] k;
        logic                  ended;
        k = '0;
        ended = 1'b0;
        for (int b = 0; b < KEY_BYTES_DEF && b < 8; b++) begin
            if (raw[8*b +: 8] == 8'h00) ended = 1'b1;
            if (!ended) k[8*b +: 8] = raw[8*b +: 8];
        end
        return k;
    endfunction

    // apply one operation to the shadow table and give the result it causes
    function automatic t_table_reply apply_table_op(input t_table_op op);
        t_table_reply          r;
        logic [KEY_TEXT_W-1:0] k;
        int                    slot;
        logic                  hit;
        r = '0;
        k = trim_key(op.key_text);
        hit = 1'b0;
        slot = 0;
        if (op.func != FUNC_NONE) begin
            for (int i = 0; i < shadow_count; i++) begin
                if (!hit && shadow_keys[i] == k) begin
                    hit = 1'b1;
                    slot = i;
                end
            end
            r.found = hit;
            case (op.func)
                FUNC_PUT: begin
                    if (hit) begin
                        shadow_vals[slot] = op.new_value;
                    end else if (shadow_count < TABLE_SLOTS) begin
                        shadow_keys[shadow_count] = k;
                        shadow_vals[shadow_count] = op.new_value;
                        shadow_count++;
                    end else begin
                        r.table_full = 1'b1;
                    end
                end
                FUNC_GET: begin
                    if (hit) r.read_value = shadow_vals[slot];
                end
                default: begin
                    // remove closes the gap by moving later entries down
                    if (hit) begin
                        for (int j = slot; j + 1 < shadow_count; j++) begin
                            shadow_keys[j] = shadow_keys[j+1];
                            shadow_vals[j] = shadow_vals[j+1];
                        end
                        shadow_count--;
                    end
                end
            endcase
        end
        r.entry_total = shadow_count[TOTAL_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, exp_val);
    endtask

    task automatic queue_op(input t_func f, input logic [KEY_TEXT_W-1:0] k,
                            input logic [VALUE_W-1:0] v);
        t_table_op op;
        op.func = f;
        op.key_text = k;
        op.new_value = v;
        pending_ops.push_back(op);
        ops_queued++;
    endtask

    // wait until every queued beat is taken and every result is back
    task automatic wait_settled();
        while (ops_accepted != ops_queued || predicted_replies.size() != 0)
            @(negedge i_clk);
    endtask

    // pool of short keys so that hits, removes and a full table are common
    task automatic build_key_pool();
        logic [KEY_TEXT_W-1:0] k;
        int                    len;
        for (int p = 0; p < POOL_SIZE; p++) begin
            len = $urandom_range(0, 8);
            k = '0;
            for (int b = 0; b < len; b++) k[8*b +: 8] = 8'($urandom_range(1, 255));
            key_pool[p] = k;
            key_pool_len[p] = len;
        end
    endtask

    // a pool key, sometimes with junk above its terminating zero byte
    function automatic logic [KEY_TEXT_W-1:0] pool_key_variant(input int p);
        logic [KEY_TEXT_W-1:0] junk;
        logic [KEY_TEXT_W-1:0] mask;
        junk = {$urandom, $urandom};
        if (key_pool_len[p] < 7 && $urandom_range(0, 1) == 1) begin
            mask = ~((64'h1 << (8 * (key_pool_len[p] + 1))) - 64'h1);
            return key_pool[p] | (junk & mask);
        end
        return key_pool[p];
    endfunction

    task automatic queue_random_op(input int mix);
        int            r;
        int            put_lim [3];
        int            get_lim [3];
        int            rem_lim [3];
        t_func         f;
        logic [KEY_TEXT_W-1:0] k;
        put_lim = '{70, 40, 15};
        get_lim = '{85, 70, 40};
        rem_lim = '{97, 95, 95};
        r = $urandom_range(0, 99);
        if (r < put_lim[mix])      f = FUNC_PUT;
        else if (r < get_lim[mix]) f = FUNC_GET;
        else if (r < rem_lim[mix]) f = FUNC_REMOVE;
        else                       f = FUNC_NONE;
        if ($urandom_range(0, 99) < 85) k = pool_key_variant($urandom_range(0, POOL_SIZE - 1));
        else                            k = {$urandom, $urandom};
        queue_op(f, k, $urandom);
    endtask

    // random traffic in chunks, with optional long receiver hold and sender pause
    task automatic random_phase(input int count, input bit with_pressure);
        int chunk;
        int mix;
        chunk = 0;
        while (count > 0) begin
            mix = $urandom_range(0, 2);
            for (int n = 0; n < 50 && count > 0; n++) begin
                queue_random_op(mix);
                count--;
            end
            while (pending_ops.size() > 8) @(negedge i_clk);
            if (with_pressure && chunk == 2) holds_asked++;
            if (with_pressure && chunk == 5) wait_settled();
            chunk++;
        end
    endtask

    // driver: new beat at the falling edge once the last one was taken
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_op = pending_ops.pop_front();
                i_in_valid  <= 1'b1;
                i_func      <= next_op.func;
                i_key_text  <= next_op.key_text;
                i_new_value <= next_op.new_value;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with long holds counted here
    always @(negedge i_clk) begin
        if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // monitor: predict on request beats, check result beats
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                seen_op.func      = t_func'(i_func);
                seen_op.key_text  = i_key_text;
                seen_op.new_value = i_new_value;
                predicted_replies.push_back(apply_table_op(seen_op));
                ops_accepted++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (predicted_replies.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding",
                                    64'(o_entry_total), 64'(0));
                end else begin
                    want = predicted_replies.pop_front();
                    if (o_found !== want.found)
                        report_mismatch("found", 64'(o_found), 64'(want.found));
                    if (o_read_value !== want.read_value)
                        report_mismatch("read_value", 64'($unsigned(o_read_value)),
                                        64'($unsigned(want.read_value)));
                    if (o_table_full !== want.table_full)
                        report_mismatch("table_full", 64'(o_table_full),
                                        64'(want.table_full));
                    if (o_entry_total !== want.entry_total)
                        report_mismatch("entry_total", 64'(o_entry_total),
                                        64'(want.entry_total));
                end
            end
        end
    end

    // main sequence
    initial begin
        build_key_pool();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, extremes, aliasing keys, unused code
        queue_op(FUNC_GET,    64'h0, 32'h0);
        queue_op(FUNC_REMOVE, 64'h0, 32'h0);
        queue_op(FUNC_NONE,   64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        queue_op(FUNC_PUT,    64'h0, 32'h8000_0000);
        queue_op(FUNC_GET,    64'hFFFF_FFFF_FFFF_FF00, 32'h1234_5678);
        queue_op(FUNC_PUT,    64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF);
        queue_op(FUNC_PUT,    64'h0000_0000_0000_4241, 32'hFFFF_FFFF);
        queue_op(FUNC_GET,    64'hDEAD_BEEF_0042_4241, 32'h0);
        queue_op(FUNC_PUT,    64'h5500_0000_0000_4241, 32'h0);
        // fill up to capacity, then overflow
        for (int i = 3; i < TABLE_SLOTS; i++)
            queue_op(FUNC_PUT, 64'h4B00 + i, $urandom);
        queue_op(FUNC_PUT,    64'h1122_3344_5566_7788, 32'h0BAD_F00D);
        queue_op(FUNC_PUT,    64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000);
        queue_op(FUNC_GET,    64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        // removes at the head, the tail and the middle
        queue_op(FUNC_REMOVE, 64'h0, 32'h0);
        queue_op(FUNC_REMOVE, 64'h4B00 + TABLE_SLOTS - 1, 32'h0);
        queue_op(FUNC_REMOVE, 64'h0000_0000_0000_4241, 32'h0);
        queue_op(FUNC_NONE,   64'h0, 32'h0);
        queue_op(FUNC_GET,    64'h0000_0000_0000_4241, 32'h0);
        wait_settled();

        // sender mostly busy, receiver mostly stalling
        random_phase(450, 1'b1);
        wait_settled();

        // sender mostly idle, receiver mostly ready
        send_idle_pct = 68;
        recv_idle_pct = 7;
        random_phase(450, 1'b1);
        wait_settled();

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(400, 1'b0);
        wait_settled();

        repeat (DRAIN_GAP) @(negedge i_clk);
        if (predicted_replies.size() != 0)
            report_mismatch("results never delivered", 64'(0),
                            64'(predicted_replies.size()));
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ckvt_pkg.sv
hdl/ckvt_ctrl.sv
hdl/ckvt_datapath.sv
hdl/compacting_key_value_table.sv
tb/testbench.sv
